FILE: rtl/hrlp_pkg.sv
package hrlp_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned OUT_OFFSET_BITS = 16;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  localparam offset_t OFFSET_MAX = {OFFSET_BITS{1'b1}};

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_METHOD     = 4'd1,
    PH_SP_URI     = 4'd2,
    PH_URI        = 4'd3,
    PH_HTTP       = 4'd4,
    PH_H          = 4'd5,
    PH_HT         = 4'd6,
    PH_HTT        = 4'd7,
    PH_HTTP_SLASH = 4'd8,
    PH_MAJ_FIRST  = 4'd9,
    PH_MAJ        = 4'd10,
    PH_MIN_FIRST  = 4'd11,
    PH_MIN        = 4'd12,
    PH_SP_END     = 4'd13,
    PH_ALMOST     = 4'd14
  } phase_e;

  typedef enum logic [1:0] {
    ST_MORE        = 2'd0,
    ST_DONE        = 2'd1,
    ST_BAD_METHOD  = 2'd2,
    ST_BAD_REQUEST = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_GET     = 2'd0,
    KIND_POST    = 2'd1,
    KIND_HEAD    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    offset_t     pos;
    offset_t     method_begin;
    logic [31:0] letters;
    kind_e       kind;
    logic [7:0]  major;
    logic [7:0]  minor;
    offset_t     uri_begin;
    offset_t     uri_finish;
    offset_t     term_at;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    phase:        PH_START,
    pos:          '0,
    method_begin: '0,
    letters:      '0,
    kind:         KIND_UNKNOWN,
    major:        '0,
    minor:        '0,
    uri_begin:    '0,
    uri_finish:   '0,
    term_at:      '0
  };

  // result item, first field in the highest bits
  typedef struct packed {
    logic [OUT_OFFSET_BITS-1:0] byte_offset;
    logic [OUT_OFFSET_BITS-1:0] line_end_offset;
    logic [OUT_OFFSET_BITS-1:0] uri_end_offset;
    logic [OUT_OFFSET_BITS-1:0] uri_start_offset;
    logic [7:0]                 version_minor;
    logic [7:0]                 version_major;
    kind_e                      method_code;
    status_e                    status;
  } result_t;

  localparam int unsigned RESULT_BITS = $bits(result_t);
  localparam int unsigned RESULT_BYTES = (RESULT_BITS + 7) / 8;
  localparam int unsigned OUT_TDATA_BITS = RESULT_BYTES * 8;

endpackage

FILE: rtl/http_request_line_parser.sv
// a result item is registered in the output register from the byte held in the input register
// throughput: one byte per cycle unless the output stalls; one pass through the step logic
// a stalled output holds both stages; the input register keeps taking a byte while it drains
// reset: asynchronous, active low; returns to the start phase with all offsets at zero
// done or any error clears the per-line state after its result is produced
module http_request_line_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // data_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, method_code, version_major, version_minor, uri_start_offset,
  // uri_end_offset, line_end_offset, byte_offset, zero pad
  output logic [hrlp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  hrlp_pkg::result_t out_res_q;
  hrlp_pkg::state_t  state_q;
  hrlp_pkg::state_t  state_d;
  hrlp_pkg::result_t step_res;
  logic              out_free;
  logic              step_en;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_en       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  hrlp_step u_step (
    .cur_i       (state_q),
    .data_byte_i (in_byte_q),
    .nxt_o       (state_d),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= hrlp_pkg::STATE_CLEAR;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_free) out_valid_q <= in_valid_q;
      if (step_en) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
    if (step_en) out_res_q <= step_res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = hrlp_pkg::OUT_TDATA_BITS'(out_res_q);

  // a finished or failed line leaves the parser at the start with a fresh count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en && step_res.status != hrlp_pkg::ST_MORE
    |=> state_q.phase == hrlp_pkg::PH_START && state_q.pos == '0)
    else $error("line state not cleared after end of line");

  // every processed byte lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> m_axis_tvalid)
    else $error("processed byte produced no result item");

  // the position counts up by one per byte inside a line until it saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en && step_res.status == hrlp_pkg::ST_MORE && state_q.pos != hrlp_pkg::OFFSET_MAX
    |=> state_q.pos == $past(state_q.pos) + hrlp_pkg::OFFSET_BITS'(1))
    else $error("byte position did not advance");

  // state only moves when a byte is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en |=> $stable(state_q))
    else $error("parser state changed without a byte");

endmodule

FILE: rtl/hrlp_step.sv
module hrlp_step (
  input  hrlp_pkg::state_t  cur_i,
  input  logic [7:0]        data_byte_i,
  output hrlp_pkg::state_t  nxt_o,
  output hrlp_pkg::result_t res_o
);

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5a;
  localparam logic [7:0] CH_US    = 8'h5f;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam logic [31:0] WORD_GET  = 32'h0047_4554;
  localparam logic [31:0] WORD_POST = 32'h504f_5354;
  localparam logic [31:0] WORD_HEAD = 32'h4845_4144;

  function automatic logic is_method_char(input logic [7:0] c);
    return (c inside {[CH_A:CH_Z]}) || (c == CH_US);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  // v * 10 + digit, clamped to 255
  function automatic logic [7:0] sat_digit(input logic [7:0] v, input logic [7:0] c);
    logic [11:0] r;
    r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'h00, c[3:0]};
    return (r > 12'd255) ? 8'hff : r[7:0];
  endfunction

  function automatic logic [15:0] to_out(input hrlp_pkg::offset_t x);
    logic [31:0] w;
    w = 32'(x);
    return w[15:0];
  endfunction

  hrlp_pkg::state_t    upd;
  hrlp_pkg::status_e   st;
  hrlp_pkg::offset_t   here;
  hrlp_pkg::offset_t   mlen;
  logic [7:0]          c;

  assign c    = data_byte_i;
  assign here = cur_i.pos;
  assign mlen = here - cur_i.method_begin;

  always_comb begin
    upd = cur_i;
    st  = hrlp_pkg::ST_MORE;
    case (cur_i.phase)
      hrlp_pkg::PH_START: begin
        upd.method_begin = here;
        if (c == CH_CR || c == CH_LF) begin
          // leading line breaks are skipped
        end else if (!is_method_char(c)) begin
          st = hrlp_pkg::ST_BAD_METHOD;
        end else begin
          upd.letters = {24'h0, c};
          upd.phase   = hrlp_pkg::PH_METHOD;
        end
      end
      hrlp_pkg::PH_METHOD: begin
        if (c == CH_SP) begin
          if (mlen == hrlp_pkg::OFFSET_BITS'(3) && cur_i.letters == WORD_GET) begin
            upd.kind = hrlp_pkg::KIND_GET;
          end else if (mlen == hrlp_pkg::OFFSET_BITS'(4) && cur_i.letters == WORD_POST) begin
            upd.kind = hrlp_pkg::KIND_POST;
          end else if (mlen == hrlp_pkg::OFFSET_BITS'(4) && cur_i.letters == WORD_HEAD) begin
            upd.kind = hrlp_pkg::KIND_HEAD;
          end else begin
            upd.kind = hrlp_pkg::KIND_UNKNOWN;
          end
          upd.phase = hrlp_pkg::PH_SP_URI;
        end else if (!is_method_char(c)) begin
          st = hrlp_pkg::ST_BAD_METHOD;
        end else begin
          upd.letters = {cur_i.letters[23:0], c};
        end
      end
      hrlp_pkg::PH_SP_URI: begin
        if (c == CH_SLASH) begin
          upd.uri_begin = here;
          upd.phase     = hrlp_pkg::PH_URI;
        end else if (c != CH_SP) begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      hrlp_pkg::PH_URI: begin
        if (c == CH_SP) begin
          upd.uri_finish = here;
          upd.phase      = hrlp_pkg::PH_HTTP;
        end
      end
      hrlp_pkg::PH_HTTP: begin
        if (c == CH_H) upd.phase = hrlp_pkg::PH_H;
        else if (c != CH_SP) st = hrlp_pkg::ST_BAD_REQUEST;
      end
      hrlp_pkg::PH_H: begin
        if (c == CH_T) upd.phase = hrlp_pkg::PH_HT;
        else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      hrlp_pkg::PH_HT: begin
        if (c == CH_T) upd.phase = hrlp_pkg::PH_HTT;
        else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      hrlp_pkg::PH_HTT: begin
        if (c == CH_P) upd.phase = hrlp_pkg::PH_HTTP_SLASH;
        else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      hrlp_pkg::PH_HTTP_SLASH: begin
        if (c == CH_SLASH) upd.phase = hrlp_pkg::PH_MAJ_FIRST;
        else st = hrlp_pkg::ST_BAD_REQUEST;
      end
      hrlp_pkg::PH_MAJ_FIRST: begin
        if (c inside {[CH_ONE:CH_NINE]}) begin
          upd.major = {4'h0, c[3:0]};
          upd.phase = hrlp_pkg::PH_MAJ;
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      hrlp_pkg::PH_MAJ: begin
        if (c == CH_DOT) upd.phase = hrlp_pkg::PH_MIN_FIRST;
        else if (!is_digit(c)) st = hrlp_pkg::ST_BAD_REQUEST;
        else upd.major = sat_digit(cur_i.major, c);
      end
      hrlp_pkg::PH_MIN_FIRST: begin
        if (is_digit(c)) begin
          upd.minor = {4'h0, c[3:0]};
          upd.phase = hrlp_pkg::PH_MIN;
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      hrlp_pkg::PH_MIN, hrlp_pkg::PH_SP_END: begin
        if (c == CH_CR) begin
          upd.term_at = here;
          upd.phase   = hrlp_pkg::PH_ALMOST;
        end else if (c == CH_LF) begin
          upd.term_at = here;
          st          = hrlp_pkg::ST_DONE;
        end else if (c == CH_SP) begin
          upd.phase = hrlp_pkg::PH_SP_END;
        end else if (cur_i.phase == hrlp_pkg::PH_MIN && is_digit(c)) begin
          upd.minor = sat_digit(cur_i.minor, c);
        end else begin
          st = hrlp_pkg::ST_BAD_REQUEST;
        end
      end
      hrlp_pkg::PH_ALMOST: begin
        st = (c == CH_LF) ? hrlp_pkg::ST_DONE : hrlp_pkg::ST_BAD_REQUEST;
      end
      default: begin
        upd.phase = hrlp_pkg::PH_START;
      end
    endcase
  end

  // result shows values after this byte, before any end-of-line clear
  always_comb begin
    res_o.status           = st;
    res_o.method_code      = upd.kind;
    res_o.version_major    = upd.major;
    res_o.version_minor    = upd.minor;
    res_o.uri_start_offset = to_out(upd.uri_begin);
    res_o.uri_end_offset   = to_out(upd.uri_finish);
    res_o.line_end_offset  = to_out(upd.term_at);
    res_o.byte_offset      = to_out(here);
  end

  always_comb begin
    if (st != hrlp_pkg::ST_MORE) begin
      nxt_o = hrlp_pkg::STATE_CLEAR;
    end else begin
      nxt_o = upd;
      if (here != hrlp_pkg::OFFSET_MAX) nxt_o.pos = here + hrlp_pkg::OFFSET_BITS'(1);
    end
  end

endmodule
